@@ rtl/core/assert_macros.svh @@
// Assertion helper macros for the frame builder RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked at the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/tcpfb_pkg.sv @@
// Shared types and constants for the TCP/IPv4 frame builder.
// No dependencies.
`timescale 1ns / 1ps
package tcpfb_pkg;
  localparam int PAYLOAD_DEPTH_DEF = 1024;
  localparam int LEN_W = 11;
  localparam int TTL_VAL = 64;
  localparam int WINDOW_VAL = 5840;
  localparam int MSS_VAL = 1460;
  localparam int HDR_MAX = 58;
  localparam int IP_OFF = 14;
  localparam int TCP_OFF = 34;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_BUILD  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOFRAME = 2'd2,
    ST_PENDING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    REG_SRC_MAC  = 4'd0,
    REG_DST_MAC  = 4'd1,
    REG_SRC_IP   = 4'd2,
    REG_DST_IP   = 4'd3,
    REG_SRC_PORT = 4'd4,
    REG_DST_PORT = 4'd5,
    REG_MODE     = 4'd6
  } reg_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SUM,
    BS_FOLD,
    BS_OUT
  } bstate_t;

  // Command passed from the front part to the back part.
  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [15:0] pid;
    logic [31:0] seq;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic             last_byte;
    logic [LEN_W-1:0] frame_length;
    status_t          status;
  } res_t;

  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] a;
    logic [16:0] b;
    begin
      a = {1'b0, s[31:16]} + {1'b0, s[15:0]};
      b = {1'b0, a[15:0]} + {16'd0, a[16]};
      fold16 = ~b[15:0];
    end
  endfunction
endpackage

@@ rtl/core/tcpfb_front.sv @@
// Front part: accepts input transfers into a short command queue.
// Depends on tcpfb_pkg.
`timescale 1ns / 1ps
module tcpfb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcpfb_pkg::cmd_t    in_cmd,
  output logic               q_valid,
  input  logic               q_ready,
  output tcpfb_pkg::cmd_t    q_cmd
);
  import tcpfb_pkg::*;

  cmd_t       mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

@@ rtl/core/tcpfb_back.sv @@
// Back part: payload buffer, checksums, header generation and byte output.
// Depends on tcpfb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcpfb_back #(
  parameter int PAYLOAD_DEPTH = tcpfb_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  tcpfb_pkg::cmd_t      q_cmd,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output tcpfb_pkg::res_t      res
);
  import tcpfb_pkg::*;

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [47:0] smac_r, dmac_r;
  logic [31:0] sip_r, dip_r;
  logic [15:0] sport_r, dport_r;
  logic [2:0]  mode_r;

  // snapshot taken at build
  logic [47:0] h_smac_r, h_dmac_r;
  logic [31:0] h_sip_r, h_dip_r, h_seq_r;
  logic [15:0] h_sport_r, h_dport_r, h_pid_r;
  logic [2:0]  h_mode_r;
  logic [15:0] ipck_r, tcpck_r;

  logic [7:0]       store_r [PAYLOAD_DEPTH];
  logic [7:0]       rd_data_r;
  logic [LEN_W-1:0] pcount_r;
  logic [31:0]      psum_r;
  logic             ready_r;
  logic [LEN_W-1:0] rpos_r;

  bstate_t     st_r, st_nxt;
  logic [2:0]  step_r;
  logic [31:0] acc_ip_r, acc_tcp_r;
  res_t        res_r;
  cmd_t        cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smac_r <= '0; dmac_r <= '0; sip_r <= '0; dip_r <= '0;
      sport_r <= '0; dport_r <= '0; mode_r <= 3'd5;
    end else if (cfg_we) begin
      case (reg_t'(cfg_index))
        REG_SRC_MAC:  smac_r  <= cfg_data;
        REG_DST_MAC:  dmac_r  <= cfg_data;
        REG_SRC_IP:   sip_r   <= cfg_data[31:0];
        REG_DST_IP:   dip_r   <= cfg_data[31:0];
        REG_SRC_PORT: sport_r <= cfg_data[15:0];
        REG_DST_PORT: dport_r <= cfg_data[15:0];
        REG_MODE:     mode_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] hlen, tcp_len, total;
  assign hlen    = h_mode_r[2] ? LEN_W'(TCP_OFF + 24) : LEN_W'(TCP_OFF + 20);
  assign tcp_len = hlen - LEN_W'(TCP_OFF) + pcount_r;
  assign total   = hlen + pcount_r;

  logic [LEN_W-1:0] n_hlen, n_tcplen;
  assign n_hlen   = mode_r[2] ? LEN_W'(TCP_OFF + 24) : LEN_W'(TCP_OFF + 20);
  assign n_tcplen = n_hlen - LEN_W'(TCP_OFF) + pcount_r;

  // header byte at a position, checksums from the registered results
  function automatic logic [7:0] hbyte(input logic [5:0] p);
    logic [15:0] iplen;
    begin
      iplen = 16'(tcp_len) + 16'd20;
      case (p)
        6'd0: hbyte = h_dmac_r[47:40]; 6'd1: hbyte = h_dmac_r[39:32];
        6'd2: hbyte = h_dmac_r[31:24]; 6'd3: hbyte = h_dmac_r[23:16];
        6'd4: hbyte = h_dmac_r[15:8];  6'd5: hbyte = h_dmac_r[7:0];
        6'd6: hbyte = h_smac_r[47:40]; 6'd7: hbyte = h_smac_r[39:32];
        6'd8: hbyte = h_smac_r[31:24]; 6'd9: hbyte = h_smac_r[23:16];
        6'd10: hbyte = h_smac_r[15:8]; 6'd11: hbyte = h_smac_r[7:0];
        6'd12: hbyte = 8'h08; 6'd14: hbyte = 8'h45;
        6'd16: hbyte = iplen[15:8]; 6'd17: hbyte = iplen[7:0];
        6'd18: hbyte = h_pid_r[15:8]; 6'd19: hbyte = h_pid_r[7:0];
        6'd22: hbyte = 8'(TTL_VAL); 6'd23: hbyte = 8'd6;
        6'd24: hbyte = ipck_r[15:8]; 6'd25: hbyte = ipck_r[7:0];
        6'd26: hbyte = h_sip_r[31:24]; 6'd27: hbyte = h_sip_r[23:16];
        6'd28: hbyte = h_sip_r[15:8];  6'd29: hbyte = h_sip_r[7:0];
        6'd30: hbyte = h_dip_r[31:24]; 6'd31: hbyte = h_dip_r[23:16];
        6'd32: hbyte = h_dip_r[15:8];  6'd33: hbyte = h_dip_r[7:0];
        6'd34: hbyte = h_sport_r[15:8]; 6'd35: hbyte = h_sport_r[7:0];
        6'd36: hbyte = h_dport_r[15:8]; 6'd37: hbyte = h_dport_r[7:0];
        6'd38: hbyte = h_seq_r[31:24]; 6'd39: hbyte = h_seq_r[23:16];
        6'd40: hbyte = h_seq_r[15:8];  6'd41: hbyte = h_seq_r[7:0];
        6'd45: hbyte = {7'd0, h_mode_r[1]};
        6'd46: hbyte = h_mode_r[2] ? 8'h60 : 8'h50;
        6'd47: hbyte = {3'd0, h_mode_r[1], 2'd0, h_mode_r[0], 1'b0};
        6'd48: hbyte = 8'(WINDOW_VAL >> 8); 6'd49: hbyte = 8'(WINDOW_VAL);
        6'd50: hbyte = tcpck_r[15:8]; 6'd51: hbyte = tcpck_r[7:0];
        6'd54: hbyte = h_mode_r[2] ? 8'd2 : 8'd0;
        6'd55: hbyte = h_mode_r[2] ? 8'd4 : 8'd0;
        6'd56: hbyte = h_mode_r[2] ? 8'(MSS_VAL >> 8) : 8'd0;
        6'd57: hbyte = h_mode_r[2] ? 8'(MSS_VAL) : 8'd0;
        default: hbyte = 8'd0;
      endcase
    end
  endfunction

  // checksum terms, one group per step
  logic [31:0] ip_term, tcp_term;
  always_comb begin
    ip_term = 32'd0;
    tcp_term = 32'd0;
    case (step_r)
      3'd0: begin
        ip_term  = 32'h4500 + 32'(16'(tcp_len) + 16'd20) + 32'(h_pid_r);
        tcp_term = psum_r + 32'(tcp_len) + 32'd6;
      end
      3'd1: begin
        ip_term  = 32'((TTL_VAL << 8) | 6) + 32'(h_sip_r[31:16]) + 32'(h_sip_r[15:0]);
        tcp_term = 32'(h_sip_r[31:16]) + 32'(h_sip_r[15:0])
                 + 32'(h_dip_r[31:16]) + 32'(h_dip_r[15:0]);
      end
      3'd2: begin
        ip_term  = 32'(h_dip_r[31:16]) + 32'(h_dip_r[15:0]);
        tcp_term = 32'(h_sport_r) + 32'(h_dport_r)
                 + 32'(h_seq_r[31:16]) + 32'(h_seq_r[15:0]);
      end
      3'd3: begin
        tcp_term = 32'(h_mode_r[1]) + 32'({h_mode_r[2] ? 4'h6 : 4'h5, 7'd0,
                   h_mode_r[1], 2'd0, h_mode_r[0], 1'b0}) + 32'(WINDOW_VAL);
        if (h_mode_r[2]) tcp_term = tcp_term + 32'h0204 + 32'(MSS_VAL);
      end
      default: ;
    endcase
  end

  // result loaded when a command is taken from the queue
  res_t res_ld;
  always_comb begin
    res_ld = '0;
    case (q_cmd.op)
      OP_APPEND: begin
        if (ready_r) res_ld.status = ST_PENDING;
        else if (pcount_r >= LEN_W'(PAYLOAD_DEPTH)) res_ld.status = ST_FULL;
      end
      OP_BUILD: res_ld.frame_length = n_hlen + pcount_r;
      OP_READ: begin
        if (!ready_r) res_ld.status = ST_NOFRAME;
        else res_ld.frame_byte = hbyte(rpos_r[5:0]);
      end
      default: ;
    endcase
  end

  logic          do_rd;
  logic [AW-1:0] rd_addr;
  logic [LEN_W-1:0] poff;
  assign poff    = rpos_r - hlen;
  assign rd_addr = poff[AW-1:0];

  always_comb begin
    st_nxt  = st_r;
    q_ready = 1'b0;
    do_rd   = 1'b0;
    case (st_r)
      BS_IDLE: if (q_valid) begin
        q_ready = 1'b1;
        st_nxt  = (q_cmd.op == OP_BUILD) ? BS_SUM : BS_OUT;
        do_rd   = (q_cmd.op == OP_READ);
      end
      BS_SUM:  if (step_r == 3'd3) st_nxt = BS_FOLD;
      BS_FOLD: st_nxt = BS_OUT;
      BS_OUT:  if (res_ready) st_nxt = BS_IDLE;
      default: st_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_rd) rd_data_r <= store_r[rd_addr];
    if (st_r == BS_IDLE && q_valid && q_cmd.op == OP_APPEND && !ready_r
        && pcount_r < LEN_W'(PAYLOAD_DEPTH)) begin
      store_r[pcount_r[AW-1:0]] <= q_cmd.data;
    end
  end

  // last flag computed combinationally from position at delivery
  logic last_now;
  assign last_now = (cur_r.op == OP_READ) && ready_r && (res_r.status == ST_OK)
                    && (rpos_r + 1'b1 >= total);

  assign res_valid = (st_r == BS_OUT);
  always_comb begin
    res = res_r;
    res.last_byte = last_now;
    if (cur_r.op == OP_READ && res_r.status == ST_OK && rpos_r >= hlen) begin
      res.frame_byte = rd_data_r;
    end
  end

  // position of the byte being delivered is the pre-increment rpos
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE; pcount_r <= '0; psum_r <= '0; ready_r <= 1'b0;
      rpos_r <= '0; step_r <= '0;
      h_pid_r <= '0; h_seq_r <= '0; ipck_r <= '0; tcpck_r <= '0;
      h_mode_r <= 3'd5;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        BS_IDLE: if (q_valid) begin
          cur_r <= q_cmd;
          res_r <= res_ld;
          case (q_cmd.op)
            OP_APPEND: begin
              if (!ready_r && pcount_r < LEN_W'(PAYLOAD_DEPTH)) begin
                psum_r <= psum_r + (pcount_r[0] ? 32'(q_cmd.data)
                                                : {16'd0, q_cmd.data, 8'd0});
                pcount_r <= pcount_r + 1'b1;
              end
            end
            OP_BUILD: begin
              h_smac_r <= smac_r; h_dmac_r <= dmac_r;
              h_sip_r <= sip_r; h_dip_r <= dip_r;
              h_sport_r <= sport_r; h_dport_r <= dport_r;
              h_mode_r <= mode_r; h_pid_r <= q_cmd.pid; h_seq_r <= q_cmd.seq;
              acc_ip_r <= '0; acc_tcp_r <= '0; step_r <= '0;
              ready_r <= 1'b1; rpos_r <= '0;
            end
            default: ;
          endcase
        end
        BS_SUM: begin
          acc_ip_r  <= acc_ip_r + ip_term;
          acc_tcp_r <= acc_tcp_r + tcp_term;
          step_r    <= step_r + 1'b1;
        end
        BS_FOLD: begin
          ipck_r  <= fold16(acc_ip_r);
          tcpck_r <= fold16(acc_tcp_r);
        end
        BS_OUT: if (res_ready) begin
          if (cur_r.op == OP_READ && ready_r) begin
            if (rpos_r + 1'b1 >= total) begin
              ready_r <= 1'b0; rpos_r <= '0; pcount_r <= '0; psum_r <= '0;
            end else begin
              rpos_r <= rpos_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_hold, clk, rst_n, res_valid && !res_ready, st_nxt == BS_OUT)
  `ASSERT_IMPL(a_noq_busy, clk, rst_n, st_r != BS_IDLE, !q_ready)
  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, pcount_r <= LEN_W'(PAYLOAD_DEPTH))
  `ASSERT_NEXT(a_build_ready, clk, rst_n, st_r == BS_IDLE && q_valid && q_cmd.op == OP_BUILD, ready_r)

  // n_tcplen is not used in the header and only feeds unused_ok; it never reaches zero
  logic unused_ok;
  assign unused_ok = |n_tcplen;
endmodule

@@ rtl/core/tcp_ipv4_frame_builder.sv @@
// Top level of the TCP/IPv4 frame builder: front queue plus back engine.
// Depends on tcpfb_pkg, tcpfb_front and tcpfb_back.
//
// Usage: in_tdata carries one command per transfer (append payload byte,
// build frame, read next frame byte). Every accepted command gives one
// result transfer on out_. Append and read results are registered when the
// back engine takes the command; a build first runs the four checksum
// accumulation steps and the fold in the back engine. One command is worked
// at a time, so the back engine takes no new command until the last result
// is taken on out_. A two-entry queue in the front lets the source keep
// pushing while the back engine works or waits on out_tready. While
// out_tready is low the result holds and the queue fills, then in_tready
// drops.
// Reset (rst_n low, synchronous) clears the queue, the payload count and
// sum, the frame flag and loads header_mode 5; payload memory is not
// cleared and needs no clearing pass.
// Configuration writes are taken at any edge with cfg_we high; write only
// while no command is in flight.
`timescale 1ns / 1ps
module tcp_ipv4_frame_builder #(
  parameter int PAYLOAD_DEPTH = tcpfb_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op
  input  logic [55:0] in_tdata,   // payload_byte[7:0], packet_id[23:8], sequence_start[55:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // last_byte
  output logic [23:0] out_tdata,  // frame_byte[7:0], frame_length[18:8], status[20:19], zero
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import tcpfb_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  res_t res;

  assign in_cmd.op   = op_t'(in_tuser);
  assign in_cmd.data = in_tdata[7:0];
  assign in_cmd.pid  = in_tdata[23:8];
  assign in_cmd.seq  = in_tdata[55:24];

  tcpfb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  tcpfb_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  // last flag follows the back engine's read position at delivery
  assign out_tlast = res.last_byte;
  assign out_tdata = {3'd0, res.status, res.frame_length, res.frame_byte};
endmodule

@@ dv/tcp_ipv4_frame_builder_test.sv @@
// Testbench for tcp_ipv4_frame_builder: random and directed append/build/read
// traffic checked against a behavioral frame predictor. Depends on tcpfb_pkg.
`timescale 1ns / 1ps
module tcp_ipv4_frame_builder_test;
  import tcpfb_pkg::*;

  localparam int DEPTH = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    op_t         op;
    logic [7:0]  pbyte;
    logic [15:0] pid;
    logic [31:0] seq;
  } cmd_item_t;

  typedef struct {
    logic [7:0]  fbyte;
    logic        last;
    logic [10:0] flen;
    status_t     st;
  } frame_res_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic        out_tlast;
  logic [23:0] out_tdata;
  logic        cfg_we = 0;
  logic [3:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  tcp_ipv4_frame_builder dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predictor state: configuration, payload store, and the snapshot header.
  logic [47:0] m_src_mac, m_dst_mac;
  logic [31:0] m_src_ip, m_dst_ip;
  logic [15:0] m_src_port, m_dst_port;
  logic [2:0]  m_mode;
  logic [7:0]  pay_mem [DEPTH];
  int unsigned pay_cnt, pay_sum, rd_pos, hdr_len;
  bit          have_frame;
  logic [7:0]  hdr [HDR_MAX];

  cmd_item_t  pending_cmds[$];
  frame_res_t expected_results[$];
  int errors = 0;
  int sender_idle_pct = 0, receiver_stall_pct = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic int unsigned word_sum(input int off, input int n);
    int unsigned s = 0;
    for (int i = 0; i + 1 < n; i += 2) s += {hdr[off + i], hdr[off + i + 1]};
    if (n % 2) s += {hdr[off + n - 1], 8'h00};
    return s;
  endfunction

  function automatic logic [15:0] ones_fold(input int unsigned s);
    s = (s >> 16) + (s & 32'hffff);
    s += s >> 16;
    return ~s[15:0];
  endfunction

  function automatic void put16(input int p, input logic [15:0] v);
    hdr[p] = v[15:8];
    hdr[p + 1] = v[7:0];
  endfunction

  function automatic void snapshot_header(input logic [15:0] pid, input logic [31:0] seq);
    int unsigned tcp_hdr, tcp_len, s;
    logic [15:0] ck;
    tcp_hdr = m_mode[2] ? 24 : 20;
    tcp_len = tcp_hdr + pay_cnt;
    foreach (hdr[i]) hdr[i] = 8'h00;
    for (int i = 0; i < 6; i++) begin
      hdr[i] = m_dst_mac[47 - 8 * i -: 8];
      hdr[6 + i] = m_src_mac[47 - 8 * i -: 8];
    end
    put16(12, 16'h0800);
    hdr[IP_OFF] = 8'h45;
    put16(IP_OFF + 2, 16'(20 + tcp_len));
    put16(IP_OFF + 4, pid);
    hdr[IP_OFF + 8] = 8'(TTL_VAL);
    hdr[IP_OFF + 9] = 8'd6;
    put16(IP_OFF + 12, m_src_ip[31:16]);
    put16(IP_OFF + 14, m_src_ip[15:0]);
    put16(IP_OFF + 16, m_dst_ip[31:16]);
    put16(IP_OFF + 18, m_dst_ip[15:0]);
    ck = ones_fold(word_sum(IP_OFF, 20));
    put16(IP_OFF + 10, ck);
    put16(TCP_OFF, m_src_port);
    put16(TCP_OFF + 2, m_dst_port);
    put16(TCP_OFF + 4, seq[31:16]);
    put16(TCP_OFF + 6, seq[15:0]);
    put16(TCP_OFF + 10, m_mode[1] ? 16'd1 : 16'd0);
    hdr[TCP_OFF + 12] = 8'((tcp_hdr / 4) << 4);
    hdr[TCP_OFF + 13] = {3'b000, m_mode[1], 2'b00, m_mode[0], 1'b0};
    put16(TCP_OFF + 14, 16'(WINDOW_VAL));
    if (m_mode[2]) begin
      hdr[TCP_OFF + 20] = 8'd2;
      hdr[TCP_OFF + 21] = 8'd4;
      put16(TCP_OFF + 22, 16'(MSS_VAL));
    end
    s = word_sum(TCP_OFF, tcp_hdr) + pay_sum + m_src_ip[31:16] + m_src_ip[15:0]
        + m_dst_ip[31:16] + m_dst_ip[15:0] + 6 + tcp_len;
    put16(TCP_OFF + 16, ones_fold(s));
    hdr_len = TCP_OFF + tcp_hdr;
  endfunction

  // Work out the one result each accepted command produces.
  function automatic frame_res_t predict_frame_step(input cmd_item_t c);
    frame_res_t r = '{8'h00, 1'b0, 11'd0, ST_OK};
    int unsigned total;
    case (c.op)
      OP_APPEND: begin
        if (have_frame) r.st = ST_PENDING;
        else if (pay_cnt >= DEPTH) r.st = ST_FULL;
        else begin
          pay_mem[pay_cnt] = c.pbyte;
          pay_sum += pay_cnt[0] ? c.pbyte : (c.pbyte << 8);
          pay_cnt++;
        end
      end
      OP_BUILD: begin
        snapshot_header(c.pid, c.seq);
        have_frame = 1;
        rd_pos = 0;
        r.flen = 11'(hdr_len + pay_cnt);
      end
      OP_READ: begin
        if (!have_frame) r.st = ST_NOFRAME;
        else begin
          total = hdr_len + pay_cnt;
          r.fbyte = (rd_pos < hdr_len) ? hdr[rd_pos] : pay_mem[rd_pos - hdr_len];
          if (rd_pos + 1 >= total) begin
            r.last = 1;
            have_frame = 0;
            rd_pos = 0;
            pay_cnt = 0;
            pay_sum = 0;
          end else rd_pos++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: present queued commands, idle at random when asked to.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_frame_step(pending_cmds.pop_front()));
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_cmds.size() > (in_tvalid && in_tready ? 0 : 0) &&
            $urandom_range(99) >= sender_idle_pct) begin
          in_tvalid <= 1;
          in_tuser <= pending_cmds[0].op;
          in_tdata <= {pending_cmds[0].seq, pending_cmds[0].pid, pending_cmds[0].pbyte};
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // Monitor: compare every result transfer with the oldest expectation.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          frame_res_t e;
          e = expected_results.pop_front();
          if (out_tdata[7:0] !== e.fbyte) report_mismatch("frame_byte", out_tdata[7:0], e.fbyte);
          if (out_tlast !== e.last) report_mismatch("last_byte", out_tlast, e.last);
          if (out_tdata[18:8] !== e.flen) report_mismatch("frame_length", out_tdata[18:8], e.flen);
          if (out_tdata[20:19] !== e.st) report_mismatch("status", out_tdata[20:19], e.st);
          if (out_tdata[23:21] !== 3'b000) report_mismatch("pad bits", out_tdata[23:21], 0);
        end
      end
      // Watchdog on cycles with no transfer on either side.
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else if (++stall_cycles >= STALL_LIMIT) begin
        $display("** tcp_ipv4_frame_builder: FAILED **");
        $finish;
      end
    end
  end

  // Write one register on the port and mirror it in the predictor.
  task automatic write_reg(input reg_t idx, input logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_SRC_MAC:  m_src_mac = v;
      REG_DST_MAC:  m_dst_mac = v;
      REG_SRC_IP:   m_src_ip = v[31:0];
      REG_DST_IP:   m_dst_ip = v[31:0];
      REG_SRC_PORT: m_src_port = v[15:0];
      REG_DST_PORT: m_dst_port = v[15:0];
      default:      m_mode = v[2:0];
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_cmd(input op_t op, input logic [7:0] b = 0,
                          input logic [15:0] pid = 0, input logic [31:0] seq = 0);
    pending_cmds.push_back('{op, b, pid, seq});
  endtask

  task automatic random_config(input bit extreme);
    logic [47:0] v [7];
    for (int i = 0; i < 7; i++)
      v[i] = extreme ? {48{1'($urandom_range(1))}} : {16'($urandom), $urandom};
    write_reg(REG_SRC_MAC, v[0]);
    write_reg(REG_DST_MAC, v[1]);
    write_reg(REG_SRC_IP, v[2]);
    write_reg(REG_DST_IP, v[3]);
    write_reg(REG_SRC_PORT, v[4]);
    write_reg(REG_DST_PORT, v[5]);
    write_reg(REG_MODE, v[6]);
  endtask

  initial begin
    int pcts [4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{24, 24}};
    m_src_mac = 0; m_dst_mac = 0; m_src_ip = 0; m_dst_ip = 0;
    m_src_port = 0; m_dst_port = 0; m_mode = 3'd5;
    pay_cnt = 0; pay_sum = 0; rd_pos = 0; hdr_len = 0; have_frame = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed: read with no frame, unknown op, extremes, pending append, rebuild.
    random_config(1);
    push_cmd(OP_READ);
    push_cmd(OP_NONE, 8'hff, 16'hffff, 32'hffffffff);
    push_cmd(OP_APPEND, 8'hff);
    push_cmd(OP_APPEND, 8'h00);
    push_cmd(OP_APPEND, 8'hff);
    push_cmd(OP_BUILD, 8'h00, 16'hffff, 32'hffffffff);
    push_cmd(OP_APPEND, 8'h55);
    push_cmd(OP_BUILD, 8'hff, 16'h0000, 32'h00000000);
    for (int i = 0; i < 62; i++) push_cmd(OP_READ);
    wait_idle();

    // Fill the store to the brim under each idling pattern, then overflow by two.
    random_config(0);
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = pcts[ph][0];
      receiver_stall_pct = pcts[ph][1];
      for (int i = 0; i < (ph == 3 ? DEPTH / 4 + 2 : DEPTH / 4); i++)
        push_cmd(OP_APPEND, 8'($urandom));
      wait_idle();
    end
    push_cmd(OP_BUILD, 0, 16'($urandom), $urandom);
    wait_idle();
    // Reconfigure after build: the frame keeps its snapshot header.
    random_config(0);
    for (int i = 0; i < 60; i++) push_cmd(OP_READ);
    wait_idle();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    wait_idle();

    if (errors == 0) $display("** tcp_ipv4_frame_builder: PASSED **");
    else $display("** tcp_ipv4_frame_builder: FAILED **");
    $finish;
  end
endmodule
